// ===== design/pngsd_pkg.sv =====
`timescale 1ns / 1ps
package pngsd_pkg;

  typedef struct packed {
    logic       first;
    logic       row_start;
    logic       last;
    logic [7:0] px;
  } item_t;

  localparam int unsigned ITEM_W = $bits(item_t);

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [63:0] PNG_SIG  = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam logic [31:0] IHDR_LEN = 32'd13;

  localparam logic [7:0] BIT_DEPTH   = 8'd8;
  localparam logic [7:0] COLOUR_RGBA = 8'd6;
  localparam logic [7:0] ZLIB_CMF    = 8'h78;
  localparam logic [7:0] ZLIB_FLG    = 8'h01;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    return v[8*(3-k) +: 8];
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    return PNG_SIG[8*(7-i) +: 8];
  endfunction

endpackage

// ===== design/pngsd_front.sv =====
`timescale 1ns / 1ps
module pngsd_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned W_W  = $clog2(MAX_WIDTH + 1),
  localparam int unsigned H_W  = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned RB_W = $clog2(4 * MAX_WIDTH + 2)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [12:0]        cfg_width_i,
  input  logic [12:0]        cfg_height_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_px_i,
  input  logic               full_i,
  output logic               push_o,
  output pngsd_pkg::item_t   item_o,
  output logic [W_W-1:0]     width_o,
  output logic [H_W-1:0]     height_o
);

  logic            hdr_done_q, hdr_done_d;
  logic [W_W-1:0]  lw_q, lw_d;
  logic [H_W-1:0]  lh_q, lh_d;
  logic [RB_W-1:0] rb_q, rb_d;
  logic [H_W-1:0]  rc_q, rc_d;

  logic [31:0]     cw, ch, cw_c, ch_c;
  logic [W_W-1:0]  w_cur;
  logic [H_W-1:0]  h_cur;
  logic [RB_W-1:0] row_len, rb_inc;
  logic            accept, row_start, end_row, last;

  always_comb begin
    cw   = {19'd0, cfg_width_i};
    ch   = {19'd0, cfg_height_i};
    cw_c = (cw == 32'd0) ? 32'd1 : ((cw > MAX_WIDTH) ? MAX_WIDTH : cw);
    ch_c = (ch == 32'd0) ? 32'd1 : ((ch > MAX_HEIGHT) ? MAX_HEIGHT : ch);
    w_cur = hdr_done_q ? lw_q : cw_c[W_W-1:0];
    h_cur = hdr_done_q ? lh_q : ch_c[H_W-1:0];
    row_len   = RB_W'({w_cur, 2'b00}) + RB_W'(1);
    row_start = (rb_q == '0);
    rb_inc    = (row_start ? RB_W'(1) : rb_q) + RB_W'(1);
    end_row   = (rb_inc >= row_len);
    last      = end_row && ((rc_q + H_W'(1)) >= h_cur);
    accept    = in_valid_i && !full_i;

    hdr_done_d = hdr_done_q;
    lw_d = lw_q;
    lh_d = lh_q;
    rb_d = rb_q;
    rc_d = rc_q;
    if (accept) begin
      lw_d = w_cur;
      lh_d = h_cur;
      hdr_done_d = !last;
      if (end_row) begin
        rb_d = '0;
        rc_d = last ? '0 : rc_q + H_W'(1);
      end else begin
        rb_d = rb_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_done_q <= 1'b0;
      lw_q <= '0;
      lh_q <= '0;
      rb_q <= '0;
      rc_q <= '0;
    end else begin
      hdr_done_q <= hdr_done_d;
      lw_q <= lw_d;
      lh_q <= lh_d;
      rb_q <= rb_d;
      rc_q <= rc_d;
    end
  end

  assign in_ready_o       = !full_i;
  assign push_o           = accept;
  assign item_o.first     = !hdr_done_q;
  assign item_o.row_start = row_start;
  assign item_o.last      = last;
  assign item_o.px        = in_px_i;
  assign width_o          = w_cur;
  assign height_o         = h_cur;

endmodule

// ===== design/pngsd_fifo.sv =====
`timescale 1ns / 1ps
module pngsd_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rp_q];

endmodule

// ===== design/pngsd_div.sv =====
`timescale 1ns / 1ps
module pngsd_div #(
  parameter int unsigned IN_W    = 28,
  parameter int unsigned DIVISOR = 65535,
  localparam int unsigned N_W    = IN_W + 1,
  localparam int unsigned RC_W   = N_W - 7,
  localparam int unsigned P_W    = N_W + RC_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IN_W-1:0] dividend_i,
  output logic            done_o,
  output logic [N_W-1:0]  quot_o
);

  // The reciprocal estimate is at most one below the true quotient, so a single
  // compare against the remainder completes it.
  localparam logic [RC_W-1:0] RECIP = RC_W'((64'd1 << N_W) / 64'(DIVISOR));

  logic [N_W-1:0] x_q, quot_q;
  logic [P_W-1:0] p_q;
  logic           s1_q, s2_q, done_q;
  logic [N_W-1:0] q0, qd, rem;

  always_comb begin
    q0  = p_q[N_W +: N_W];
    qd  = q0 * N_W'(DIVISOR);
    rem = x_q - qd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
      x_q    <= '0;
      p_q    <= '0;
      quot_q <= '0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
      if (start_i) begin
        x_q <= N_W'(dividend_i) + N_W'(DIVISOR - 1);
      end
      if (s1_q) begin
        p_q <= P_W'(x_q) * P_W'(RECIP);
      end
      if (s2_q) begin
        quot_q <= q0 + N_W'(rem >= N_W'(DIVISOR));
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/pngsd_back.sv =====
`timescale 1ns / 1ps
module pngsd_back #(
  parameter int unsigned MAX_WIDTH          = 4096,
  parameter int unsigned MAX_HEIGHT         = 4096,
  parameter int unsigned STORED_BLOCK_LIMIT = 65535,
  localparam int unsigned W_W   = $clog2(MAX_WIDTH + 1),
  localparam int unsigned H_W   = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned RAW_W = $clog2(MAX_HEIGHT * (4 * MAX_WIDTH + 1) + 1),
  localparam int unsigned P_W   = H_W + W_W + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  pngsd_pkg::item_t item_i,
  input  logic [W_W-1:0]   width_i,
  input  logic [H_W-1:0]   height_i,
  output logic             pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [7:0]       m_tdata_o,
  output logic             m_tlast_o,
  output logic             m_tuser_o
);

  typedef enum logic [2:0] {ST_HEAD, ST_HDR, ST_BLK, ST_DATA, ST_TRL} state_e;

  localparam logic [5:0] HDR_ZLEN = 6'd33;
  localparam logic [5:0] HDR_LAST = 6'd42;
  localparam logic [5:0] BLK_LAST = 6'd4;
  localparam logic [5:0] TRL_LAST = 6'd19;

  state_e st_q, st_d, eff;
  logic [5:0]       idx_q, idx_d, idx3;
  logic [31:0]      crc_q, crc_d, crc_base;
  logic [15:0]      al_q, al_d, ah_q, ah_d;
  logic [15:0]      blk_q, blk_d;
  logic [RAW_W-1:0] raw_q, raw_d, rawlen_q, rawlen_d;
  logic [W_W-1:0]   w_q, w_d;
  logic [H_W-1:0]   h_q, h_d;
  logic [31:0]      zlen_q, zlen_d;
  logic             zok_q, zok_d, filt_q, filt_d;
  logic             ov_q, ob_last_q, ob_user_q;
  logic [7:0]       ob_q;

  logic             adv, produce, fire, crc_use, crc_init, run_end, file_end, div_start;
  logic [7:0]       byte_v;
  logic [15:0]      n;
  logic [16:0]      a1, a2;
  logic [P_W-1:0]   prod;
  logic             div_done;
  logic [RAW_W:0]   quot;

  pngsd_div #(.IN_W(RAW_W), .DIVISOR(STORED_BLOCK_LIMIT)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .dividend_i(rawlen_q),
    .done_o(div_done), .quot_o(quot)
  );

  always_comb begin
    eff = st_q;
    if (st_q == ST_HEAD) begin
      if (item_i.first) eff = ST_HDR;
      else if (blk_q == 16'd0) eff = ST_BLK;
      else eff = ST_DATA;
    end
    adv     = !ov_q || m_tready_i;
    produce = (st_q != ST_HEAD || item_valid_i)
              && !(eff == ST_HDR && idx_q >= HDR_ZLEN && !zok_q);
    fire    = produce && adv;
    idx3    = idx_q + 6'd3;

    if (32'(raw_q) > 32'(STORED_BLOCK_LIMIT)) n = 16'(STORED_BLOCK_LIMIT);
    else n = 16'(raw_q);

    byte_v   = 8'd0;
    crc_use  = 1'b0;
    crc_init = 1'b0;
    run_end  = 1'b0;
    file_end = 1'b0;
    unique case (eff)
      ST_HEAD: ;
      ST_HDR: begin
        priority if (idx_q < 6'd8) byte_v = pngsd_pkg::sig_byte(idx_q[2:0]);
        else if (idx_q < 6'd12) byte_v = pngsd_pkg::be_byte(pngsd_pkg::IHDR_LEN, idx_q[1:0]);
        else if (idx_q < 6'd16) begin
          byte_v = pngsd_pkg::be_byte(pngsd_pkg::TAG_IHDR, idx_q[1:0]);
          crc_use = 1'b1;
          crc_init = (idx_q == 6'd12);
        end else if (idx_q < 6'd20) begin
          byte_v = pngsd_pkg::be_byte(32'(w_q), idx_q[1:0]);
          crc_use = 1'b1;
        end else if (idx_q < 6'd24) begin
          byte_v = pngsd_pkg::be_byte(32'(h_q), idx_q[1:0]);
          crc_use = 1'b1;
        end else if (idx_q < 6'd29) begin
          if (idx_q == 6'd24) byte_v = pngsd_pkg::BIT_DEPTH;
          else if (idx_q == 6'd25) byte_v = pngsd_pkg::COLOUR_RGBA;
          crc_use = 1'b1;
        end else if (idx_q < 6'd33) byte_v = pngsd_pkg::be_byte(~crc_q, idx3[1:0]);
        else if (idx_q < 6'd37) byte_v = pngsd_pkg::be_byte(zlen_q, idx3[1:0]);
        else if (idx_q < 6'd41) begin
          byte_v = pngsd_pkg::be_byte(pngsd_pkg::TAG_IDAT, idx3[1:0]);
          crc_use = 1'b1;
          crc_init = (idx_q == 6'd37);
        end else begin
          byte_v = (idx_q == 6'd41) ? pngsd_pkg::ZLIB_CMF : pngsd_pkg::ZLIB_FLG;
          crc_use = 1'b1;
        end
      end
      ST_BLK: begin
        crc_use = 1'b1;
        unique case (idx_q[2:0])
          3'd0: byte_v = {7'd0, (32'(raw_q) <= 32'(STORED_BLOCK_LIMIT))};
          3'd1: byte_v = n[7:0];
          3'd2: byte_v = n[15:8];
          3'd3: byte_v = ~n[7:0];
          default: byte_v = ~n[15:8];
        endcase
      end
      ST_DATA: begin
        crc_use = 1'b1;
        byte_v  = (item_i.row_start && !filt_q) ? 8'd0 : item_i.px;
        run_end = !(item_i.row_start && !filt_q) && !item_i.last;
      end
      ST_TRL: begin
        priority if (idx_q < 6'd4) begin
          byte_v = pngsd_pkg::be_byte({ah_q, al_q}, idx_q[1:0]);
          crc_use = 1'b1;
        end else if (idx_q < 6'd8) byte_v = pngsd_pkg::be_byte(~crc_q, idx_q[1:0]);
        else if (idx_q < 6'd12) byte_v = 8'd0;
        else if (idx_q < 6'd16) begin
          byte_v = pngsd_pkg::be_byte(pngsd_pkg::TAG_IEND, idx_q[1:0]);
          crc_use = 1'b1;
          crc_init = (idx_q == 6'd12);
        end else byte_v = pngsd_pkg::be_byte(~crc_q, idx_q[1:0]);
        run_end  = (idx_q == TRL_LAST);
        file_end = (idx_q == TRL_LAST);
      end
      default: ;
    endcase

    crc_base = crc_init ? 32'hFFFFFFFF : crc_q;
    a1 = {1'b0, al_q} + {9'd0, byte_v};
    if (a1 >= pngsd_pkg::ADLER_MOD) a1 = a1 - pngsd_pkg::ADLER_MOD;
    a2 = {1'b0, ah_q} + a1;
    if (a2 >= pngsd_pkg::ADLER_MOD) a2 = a2 - pngsd_pkg::ADLER_MOD;
    prod = P_W'(h_q) * P_W'(P_W'({w_q, 2'b00}) + P_W'(1));

    st_d = st_q;
    idx_d = idx_q;
    crc_d = crc_q;
    al_d = al_q;
    ah_d = ah_q;
    blk_d = blk_q;
    raw_d = raw_q;
    rawlen_d = rawlen_q;
    w_d = w_q;
    h_d = h_q;
    zlen_d = zlen_q;
    zok_d = zok_q;
    filt_d = filt_q;
    pop_o = 1'b0;
    div_start = 1'b0;

    if (div_done) begin
      zlen_d = 32'(rawlen_q) + 32'(quot) + (32'(quot) << 2) + 32'd6;
      zok_d  = 1'b1;
    end

    if (fire) begin
      st_d  = eff;
      idx_d = idx_q + 6'd1;
      if (crc_use) crc_d = pngsd_pkg::crc_byte(crc_base, byte_v);
      unique case (eff)
        ST_HEAD: ;
        ST_HDR: begin
          if (idx_q == 6'd0) begin
            w_d = width_i;
            h_d = height_i;
            zok_d = 1'b0;
          end
          if (idx_q == 6'd1) rawlen_d = RAW_W'(prod);
          if (idx_q == 6'd2) div_start = 1'b1;
          if (idx_q == HDR_LAST) begin
            st_d  = ST_BLK;
            idx_d = 6'd0;
            raw_d = rawlen_q;
            blk_d = 16'd0;
            al_d  = 16'd1;
            ah_d  = 16'd0;
          end
        end
        ST_BLK: begin
          if (idx_q == BLK_LAST) begin
            blk_d = n;
            st_d  = ST_DATA;
            idx_d = 6'd0;
          end
        end
        ST_DATA: begin
          idx_d = 6'd0;
          al_d  = a1[15:0];
          ah_d  = a2[15:0];
          if (blk_q != 16'd0) blk_d = blk_q - 16'd1;
          if (raw_q != '0) raw_d = raw_q - RAW_W'(1);
          if (item_i.row_start && !filt_q) begin
            filt_d = 1'b1;
            st_d = (blk_q == 16'd1) ? ST_BLK : ST_DATA;
          end else if (item_i.last) begin
            st_d = ST_TRL;
          end else begin
            st_d   = ST_HEAD;
            pop_o  = 1'b1;
            filt_d = 1'b0;
          end
        end
        ST_TRL: begin
          if (idx_q == TRL_LAST) begin
            st_d   = ST_HEAD;
            idx_d  = 6'd0;
            pop_o  = 1'b1;
            filt_d = 1'b0;
            crc_d  = 32'hFFFFFFFF;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_HEAD;
      idx_q  <= 6'd0;
      crc_q  <= 32'hFFFFFFFF;
      al_q   <= 16'd1;
      ah_q   <= 16'd0;
      blk_q  <= 16'd0;
      raw_q  <= '0;
      zok_q  <= 1'b0;
      filt_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      crc_q  <= crc_d;
      al_q   <= al_d;
      ah_q   <= ah_d;
      blk_q  <= blk_d;
      raw_q  <= raw_d;
      zok_q  <= zok_d;
      filt_q <= filt_d;
      if (adv) ov_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    rawlen_q <= rawlen_d;
    w_q      <= w_d;
    h_q      <= h_d;
    zlen_q   <= zlen_d;
    if (fire) begin
      ob_q      <= byte_v;
      ob_last_q <= run_end;
      ob_user_q <= file_end;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = ob_q;
  assign m_tlast_o  = ob_last_q;
  assign m_tuser_o  = ob_user_q;

  a_zlen_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eff == ST_HDR && idx_q >= HDR_ZLEN) |-> zok_q)
    else $error("IDAT length sent before it was computed");
  a_blk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eff == ST_DATA) |-> (blk_q != 16'd0))
    else $error("Stored block overrun");
  a_pop_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (fire && item_valid_i))
    else $error("Item released without a transaction");
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> m_tlast_o)
    else $error("File end without run end");

endmodule

// ===== design/png_stored_deflate_encoder.sv =====
`timescale 1ns / 1ps
// A pixel byte passes through the item FIFO and the output register, behind any row filter
// byte or block header that is sent in front of it. Output: one byte per cycle while the
// output is ready and the IDAT length is known; the file header adds 43 bytes on the first
// byte of an image, each stored block 5, each row filter byte 1 and the trailer 20, all from
// the single byte-wide output sequencer. Reset clears the counters, presets the CRC to all
// ones and Adler-32 to 1, and sets the size registers to 320 by 200.
module png_stored_deflate_encoder #(
  parameter int unsigned MAX_WIDTH          = 4096,
  parameter int unsigned MAX_HEIGHT         = 4096,
  parameter int unsigned STORED_BLOCK_LIMIT = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // file_end
);

  localparam int unsigned W_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned FIFO_W = pngsd_pkg::ITEM_W + W_W + H_W;

  logic [12:0]        cfg_w_q, cfg_h_q;
  logic               full, push, pop, q_valid;
  pngsd_pkg::item_t   f_item, b_item;
  logic [W_W-1:0]     f_w, b_w;
  logic [H_W-1:0]     f_h, b_h;
  logic [FIFO_W-1:0]  q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 13'd320;
      cfg_h_q <= 13'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pngsd_pkg::CFG_WIDTH:  cfg_w_q <= cfg_wdata_i;
        pngsd_pkg::CFG_HEIGHT: cfg_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pngsd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_width_i(cfg_w_q), .cfg_height_i(cfg_h_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_px_i(s_axis_tdata),
    .full_i(full), .push_o(push), .item_o(f_item), .width_o(f_w), .height_o(f_h)
  );

  pngsd_fifo #(.DATA_W(FIFO_W)) u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .wdata_i({f_h, f_w, f_item}),
    .full_o(full), .pop_i(pop), .valid_o(q_valid), .rdata_o(q_rdata)
  );

  assign {b_h, b_w, b_item} = q_rdata;

  pngsd_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .STORED_BLOCK_LIMIT(STORED_BLOCK_LIMIT)
  ) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .item_valid_i(q_valid), .item_i(b_item),
    .width_i(b_w), .height_i(b_h), .pop_o(pop),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_o(m_axis_tdata),
    .m_tlast_o(m_axis_tlast), .m_tuser_o(m_axis_tuser)
  );

endmodule
